@@ sv/plc_pkg.sv @@
// Shared types and constants for the positional list core.
// Used by plc_cell, plc_chain and positional_list_insert_delete_core; no dependencies.
`timescale 1ns / 1ps

package plc_pkg;

   // Sizing
   localparam int CAPACITY      = 32;
   localparam int READ_LIMIT    = 32;
   localparam int DATA_W        = 32;
   localparam int KIND_W        = 3;
   localparam int POS_W         = 6;
   localparam int STATUS_W      = 2;
   localparam int COUNT_AFTER_W = 6;
   localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int CMP_W         = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] READ_CNT =
      CNT_W'((READ_LIMIT < CAPACITY) ? READ_LIMIT : CAPACITY);

   // Operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR       = 3'd0,
      KIND_INSERT      = 3'd1,
      KIND_APPEND      = 3'd2,
      KIND_DELETE      = 3'd3,
      KIND_DELETE_TAIL = 3'd4,
      KIND_READ        = 3'd5
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_RANGE = 2'd3
   } status_type;

   // What every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic [IDX_W-1:0]          idx;
      logic signed [DATA_W-1:0]  value;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // Channel words
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [DATA_W-1:0]  data;
      logic [COUNT_AFTER_W-1:0]  count_after;
      logic                      last;
   } rsp_type;

endpackage

@@ sv/plc_cell.sv @@
// One storage cell of the list chain: holds a single entry.
// Depends on plc_pkg.
`timescale 1ns / 1ps

module plc_cell (
   input  logic                           clock,
   input  plc_pkg::cell_ctl_type          ctl,
   input  logic [plc_pkg::IDX_W-1:0]      cell_idx,
   input  logic signed [plc_pkg::DATA_W-1:0] left_data,
   input  logic signed [plc_pkg::DATA_W-1:0] right_data,
   input  logic signed [plc_pkg::DATA_W-1:0] head_data,
   output logic signed [plc_pkg::DATA_W-1:0] data_ff
);
   import plc_pkg::*;

   logic signed [DATA_W-1:0] data_in;

   // Next entry: hold, take a neighbor, or take the new value
   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (cell_idx == ctl.idx) data_in = ctl.value;
            else if (cell_idx > ctl.idx) data_in = left_data;
         end
         CELL_DELETE: begin
            if (cell_idx >= ctl.idx) data_in = right_data;
         end
         CELL_ROTATE: begin
            // idx marks the tail; the head wraps around to it
            if (cell_idx == ctl.idx) data_in = head_data;
            else if (cell_idx < ctl.idx) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ sv/plc_chain.sv @@
// Row of plc_cell instances with neighbor links, head tap and indexed read.
// Depends on plc_pkg and plc_cell.
`timescale 1ns / 1ps

module plc_chain (
   input  logic                              clock,
   input  plc_pkg::cell_ctl_type             ctl,
   output logic signed [plc_pkg::DATA_W-1:0] sel_data,
   output logic signed [plc_pkg::DATA_W-1:0] head_data
);
   import plc_pkg::*;

   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   // Cells; the ends link back to themselves
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      localparam int LEFT  = (g == 0) ? 0 : g - 1;
      localparam int RIGHT = (g == CAPACITY - 1) ? g : g + 1;

      plc_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_idx   (IDX_W'(g)),
         .left_data  (cell_data[LEFT]),
         .right_data (cell_data[RIGHT]),
         .head_data  (head_data),
         .data_ff    (cell_data[g])
      );
   end

   // Entry at the control index (removed value on deletes)
   assign sel_data  = cell_data[ctl.idx];
   assign head_data = cell_data[0];

endmodule

@@ sv/positional_list_insert_delete_core.sv @@
// Top level of the positional list core: decode, count, read-out sequencer, output register.
// Depends on plc_pkg and plc_chain.
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of
// cells. The cells shift in parallel, so insert, append, delete, tail
// delete and clear finish in the cycle they are accepted and their single
// result word sits in the output register on the next cycle. A read out
// streams one result word per rotation step, as the chain rotates by one
// cell per cycle unless the output register is stalled, and always presents
// the list head; the list is back in order when it ends. A read out of an
// empty list gives a single word. The request side is stalled during a read
// out and while an undelivered result holds the output register. Failed
// operations are flagged in status and leave the list as is.
// No clearing pass after reset: entries are only read below the count.
module positional_list_insert_delete_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  plc_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output plc_pkg::rsp_type rsp_word
);
   import plc_pkg::*;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   cell_ctl_type             ctl;
   logic signed [DATA_W-1:0] sel_data;
   logic signed [DATA_W-1:0] head_data;

   logic             acc;
   logic             slot_free;
   logic             rd_emit;
   logic             rd_step;
   logic             rd_done;
   logic             load;
   logic             read_start;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic [IDX_W-1:0] pos_idx;
   logic [IDX_W-1:0] tail_idx;
   logic             is_full;
   logic             is_empty;
   rsp_type          res;

   // Handshake
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !slot_free;
   assign acc        = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // Operand checks
   assign pos_ext  = CMP_W'(req_word.position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign pos_idx  = IDX_W'(req_word.position - POS_W'(1));
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));
   assign is_full  = count_ff >= CAP_CNT;
   assign is_empty = count_ff == '0;

   assign read_start = acc && (req_word.kind == KIND_READ) && !is_empty;

   // Read-out stepping: emit while under the limit, then rotate silently
   assign rd_emit = CNT_W'(rd_idx_ff) < READ_CNT;
   assign rd_step = (state_ff == ST_READ) && (!rd_emit || slot_free);
   assign rd_done = rd_step && (rd_idx_ff == tail_idx);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (read_start) state_in = ST_READ;
         ST_READ: if (rd_done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Cell control, count update and result word
   always_comb begin
      ctl.op          = CELL_HOLD;
      ctl.idx         = pos_idx;
      ctl.value       = req_word.value;
      count_in        = count_ff;
      rd_idx_in       = rd_idx_ff;
      res.status      = STAT_OK;
      res.data        = '0;
      res.last        = 1'b1;
      load            = 1'b0;

      if (state_ff == ST_READ) begin
         ctl.op  = rd_step ? CELL_ROTATE : CELL_HOLD;
         ctl.idx = tail_idx;
         if (rd_step) rd_idx_in = rd_idx_ff + IDX_W'(1);
         load     = rd_step && rd_emit;
         res.data = head_data;
         // last word is the final one streamed: the count, capped at the limit
         res.last = (CNT_W'(rd_idx_ff) + CNT_W'(1)) ==
                    ((count_ff < READ_CNT) ? count_ff : READ_CNT);
      end else if (acc) begin
         load      = !read_start;
         rd_idx_in = '0;
         case (req_word.kind)
            KIND_CLEAR: begin
               count_in = '0;
            end
            KIND_INSERT: begin
               if (is_full) begin
                  res.status = STAT_FULL;
               end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                  res.status = STAT_RANGE;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_APPEND: begin
               ctl.idx = IDX_W'(count_ff);
               if (is_full) begin
                  res.status = STAT_FULL;
               end else begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_DELETE: begin
               if (is_empty) begin
                  res.status = STAT_EMPTY;
               end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  res.status = STAT_RANGE;
               end else begin
                  ctl.op   = CELL_DELETE;
                  res.data = sel_data;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_DELETE_TAIL: begin
               ctl.idx = tail_idx;
               if (is_empty) begin
                  res.status = STAT_EMPTY;
               end else begin
                  ctl.op   = CELL_DELETE;
                  res.data = sel_data;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_READ: begin
               // only the empty case answers here
               if (is_empty) res.status = STAT_EMPTY;
            end
            default: ;
         endcase
      end

      res.count_after = COUNT_AFTER_W'(count_in);
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   plc_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .sel_data  (sel_data),
      .head_data (head_data)
   );

`ifndef SYNTHESIS
   // Count stays within the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("list count above capacity");

   // An accepted word gives a result or starts a read out
   a_acc_progress: assert property (@(posedge clock) disable iff (reset)
      acc |=> (rsp_valid_ff || state_ff == ST_READ))
      else $error("accepted word produced nothing");

   // The list size is frozen during a read out
   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (count_ff == $past(count_ff)))
      else $error("count changed during read out");

   // Outside a read out, any held result closes its word
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && rsp_valid_ff) |-> rsp_ff.last)
      else $error("non-final result left when idle");
`endif

endmodule

@@ tb/tb_positional_list_insert_delete_core.sv @@
// Self-checking testbench for positional_list_insert_delete_core.
// Drives list operations from a queued word stream and checks every result word.
// Depends on plc_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_core;
   import plc_pkg::*;

   // One queued request word plus the traffic shape that goes with it
   typedef struct {
      req_type word;
      int      idle_pct;
      int      stall_pct;
      bit      drain;
      bit      hold;
   } stim_entry_type;

   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   stim_entry_type                stim_q[$];
   rsp_type                       expected_words[$];
   logic signed [DATA_W-1:0]      list_entries[$];

   // Traffic control shared between driver and receiver
   int stall_pct   = 0;
   int hold_events = 0;
   int hold_seen   = 0;
   int hold_left   = 0;

   // Stimulus build state
   int cur_idle   = 0;
   int cur_stall  = 0;
   bit drain_next = 1'b0;
   bit hold_next  = 1'b0;
   int gen_count  = 0;

   // Run statistics
   int items_sent    = 0;
   int words_checked = 0;
   int mismatches    = 0;
   int n_full        = 0;
   int n_empty       = 0;
   int n_range       = 0;
   int n_reads       = 0;

   positional_list_insert_delete_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Queue one expected result word; count_after reflects the list after the op
   task automatic push_expected(input status_type st, input logic signed [DATA_W-1:0] d,
                                input logic lst);
      rsp_type r;
      r.status      = st;
      r.data        = d;
      r.count_after = COUNT_AFTER_W'(list_entries.size());
      r.last        = lst;
      expected_words.push_back(r);
      case (st)
         STAT_FULL:  n_full++;
         STAT_EMPTY: n_empty++;
         STAT_RANGE: n_range++;
         default: ;
      endcase
   endtask

   // List predictor: applies one accepted word and queues its result words
   task automatic predict_list_op(input req_type w);
      int                       pos;
      int                       n;
      logic signed [DATA_W-1:0] removed;
      pos = w.position;
      case (w.kind)
         KIND_CLEAR: begin
            list_entries.delete();
            push_expected(STAT_OK, '0, 1'b1);
         end
         KIND_INSERT: begin
            // full is checked ahead of the position
            if (list_entries.size() >= CAPACITY) begin
               push_expected(STAT_FULL, '0, 1'b1);
            end else if (pos == 0 || pos > list_entries.size() + 1) begin
               push_expected(STAT_RANGE, '0, 1'b1);
            end else begin
               list_entries.insert(pos - 1, w.value);
               push_expected(STAT_OK, '0, 1'b1);
            end
         end
         KIND_APPEND: begin
            if (list_entries.size() >= CAPACITY) begin
               push_expected(STAT_FULL, '0, 1'b1);
            end else begin
               list_entries.push_back(w.value);
               push_expected(STAT_OK, '0, 1'b1);
            end
         end
         KIND_DELETE: begin
            // empty is checked ahead of the position
            if (list_entries.size() == 0) begin
               push_expected(STAT_EMPTY, '0, 1'b1);
            end else if (pos == 0 || pos > list_entries.size()) begin
               push_expected(STAT_RANGE, '0, 1'b1);
            end else begin
               removed = list_entries[pos - 1];
               list_entries.delete(pos - 1);
               push_expected(STAT_OK, removed, 1'b1);
            end
         end
         KIND_DELETE_TAIL: begin
            if (list_entries.size() == 0) begin
               push_expected(STAT_EMPTY, '0, 1'b1);
            end else begin
               removed = list_entries.pop_back();
               push_expected(STAT_OK, removed, 1'b1);
            end
         end
         KIND_READ: begin
            n_reads++;
            if (list_entries.size() == 0) begin
               push_expected(STAT_EMPTY, '0, 1'b1);
            end else begin
               n = (list_entries.size() < READ_LIMIT) ? list_entries.size() : READ_LIMIT;
               for (int i = 0; i < n; i++)
                  push_expected(STAT_OK, list_entries[i], (i == n - 1));
            end
         end
         default: begin
            // unused kinds leave the list alone
            push_expected(STAT_OK, '0, 1'b1);
         end
      endcase
   endtask

   // Stimulus build: queue a word and track the list length it will leave
   task automatic add_word(input logic [KIND_W-1:0] kind, input int pos,
                           input logic [DATA_W-1:0] val);
      stim_entry_type e;
      e.word.kind     = kind;
      e.word.position = POS_W'(pos);
      e.word.value    = val;
      e.idle_pct      = cur_idle;
      e.stall_pct     = cur_stall;
      e.drain         = drain_next;
      e.hold          = hold_next;
      drain_next      = 1'b0;
      hold_next       = 1'b0;
      stim_q.push_back(e);
      case (kind)
         KIND_CLEAR: gen_count = 0;
         KIND_INSERT:
            if (gen_count < CAPACITY && pos >= 1 && pos <= gen_count + 1) gen_count++;
         KIND_APPEND:
            if (gen_count < CAPACITY) gen_count++;
         KIND_DELETE:
            if (gen_count > 0 && pos >= 1 && pos <= gen_count) gen_count--;
         KIND_DELETE_TAIL:
            if (gen_count > 0) gen_count--;
         default: ;
      endcase
   endtask

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // One random word; mode 0 grows the list, 1 shrinks it, 2 mixes
   task automatic add_random(input int mode);
      int r;
      int grow_pct;
      int pos;
      r = $urandom_range(99);
      grow_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
      if (r < 3) begin
         add_word(KIND_W'($urandom_range(6, 7)), $urandom_range(63), $urandom);
      end else if (r < 5) begin
         add_word(KIND_CLEAR, $urandom_range(63), $urandom);
      end else if (r < 12) begin
         add_word(KIND_READ, $urandom_range(63), $urandom);
      end else if ($urandom_range(99) < grow_pct) begin
         if ($urandom_range(99) < 60) begin
            pos = ($urandom_range(99) < 85) ? $urandom_range(1, gen_count + 1)
                                            : $urandom_range(63);
            add_word(KIND_INSERT, pos, rand_value());
         end else begin
            add_word(KIND_APPEND, $urandom_range(63), rand_value());
         end
      end else begin
         if ($urandom_range(99) < 55) begin
            pos = ($urandom_range(99) < 85 && gen_count > 0) ? $urandom_range(1, gen_count)
                                                             : $urandom_range(63);
            add_word(KIND_DELETE, pos, $urandom);
         end else begin
            add_word(KIND_DELETE_TAIL, $urandom_range(63), $urandom);
         end
      end
   endtask

   // Stimulus: directed corner words, then four traffic phases of random bursts
   initial begin
      int burst_len;
      int mode;
      int made;

      // empty list corners
      add_word(KIND_CLEAR, 0, '0);
      add_word(KIND_READ, 0, '0);
      add_word(KIND_DELETE, 1, '0);
      add_word(KIND_DELETE_TAIL, 0, '0);
      add_word(KIND_INSERT, 0, 32'h1111_1111);
      add_word(KIND_INSERT, 2, 32'h2222_2222);
      // value extremes, head insert, insert at count+1, middle insert
      add_word(KIND_INSERT, 1, 32'h7fff_ffff);
      add_word(KIND_APPEND, 0, 32'h8000_0000);
      add_word(KIND_APPEND, 63, 32'hffff_ffff);
      add_word(KIND_INSERT, 1, 32'h0000_0000);
      add_word(KIND_INSERT, 5, 32'h1234_5678);
      add_word(KIND_INSERT, 2, $urandom);
      add_word(KIND_READ, 0, '0);
      // delete position corners
      add_word(KIND_DELETE, 0, '0);
      add_word(KIND_DELETE, 7, '0);
      add_word(KIND_DELETE, 63, '0);
      add_word(KIND_DELETE, 3, '0);
      add_word(KIND_DELETE, 1, '0);
      add_word(KIND_DELETE_TAIL, 0, '0);
      // unused kinds
      add_word(KIND_W'(6), 0, '0);
      add_word(KIND_W'(7), 63, 32'hffff_ffff);
      add_word(KIND_READ, 0, '0);
      add_word(KIND_CLEAR, 0, '0);
      add_word(KIND_READ, 0, '0);

      // traffic phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         cur_idle   = (ph == 1) ? 83 : (ph == 3) ? 24 : 0;
         cur_stall  = (ph == 2) ? 83 : (ph == 3) ? 24 : 0;
         drain_next = 1'b1;
         made = 0;
         while (made < 120) begin
            mode = $urandom_range(2);
            burst_len = $urandom_range(10, 40);
            for (int i = 0; i < burst_len && made < 120; i++) begin
               // long receiver hold-off while the sender keeps offering
               if (ph == 0 && made == 40) hold_next = 1'b1;
               add_random(mode);
               made++;
            end
         end
      end
   end

   // Driver: one word at a time, held steady while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_list_op(req_word);
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (stim_q.size() != 0 && !(stim_q[0].drain && expected_words.size() != 0)
                && $urandom_range(99) >= stim_q[0].idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= stim_q[0].word;
               stall_pct <= stim_q[0].stall_pct;
               if (stim_q[0].hold) hold_events <= hold_events + 1;
               stim_q.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall, plus a long counted hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_events != hold_seen) begin
         hold_seen <= hold_events;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: status %0d data %0h count %0d last %0b",
                        rsp_word.status, rsp_word.data, rsp_word.count_after, rsp_word.last);
         end else begin
            e = expected_words.pop_front();
            words_checked++;
            if (rsp_word.status !== e.status || rsp_word.data !== e.data ||
                rsp_word.count_after !== e.count_after || rsp_word.last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch at word %0d: exp st %0d d %0h c %0d l %0b, got st %0d d %0h c %0d l %0b",
                           words_checked, e.status, e.data, e.count_after, e.last,
                           rsp_word.status, rsp_word.data, rsp_word.count_after,
                           rsp_word.last);
            end
         end
      end
   end

   // End of run: all words sent, all results in, then a short quiet tail
   initial begin
      @(negedge clock);
      while (reset || stim_q.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_words.size() != 0) mismatches++;
      $display("Ran %0d list operations (%0d read outs), checked %0d result words.",
               items_sent, n_reads, words_checked);
      $display("Flagged results seen: %0d full, %0d empty, %0d bad position.",
               n_full, n_empty, n_range);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
